@@ hw/rtl/card_flash_id_descramble_assert.svh @@
// ----------------------------------------------------------------------------
// card_flash_id_descramble_assert.svh
// Assertion macros shared by the descrambler RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CARD_FLASH_ID_DESCRAMBLE_ASSERT_SVH
`define CARD_FLASH_ID_DESCRAMBLE_ASSERT_SVH

`ifndef SYNTHESIS
`define CDFI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdfi assertion failed");
`define CDFI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdfi assertion failed");
`else
`define CDFI_ASSERT_IMPL(label, ante, cons)
`define CDFI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/cdfi_pkg.sv @@
// ----------------------------------------------------------------------------
// cdfi_pkg
// Types and constants of the card flash ID descrambler.
// ----------------------------------------------------------------------------
package cdfi_pkg;

    localparam int ID_BYTES = 12;
    localparam int ID_W     = ID_BYTES * 8;
    localparam int CNT_W    = $clog2(ID_BYTES);
    localparam int OPND_W   = 32;
    localparam int MUL_W    = 31;
    localparam int PROD_W   = OPND_W + MUL_W;
    localparam int X_W      = 64;
    localparam int SHIFT    = 16;
    localparam int MASK_W   = 15;

    localparam logic [MUL_W-1:0] LCG_MUL  = 31'h41c6_4e6d;
    localparam logic [15:0]      LCG_ADD  = 16'h3039;
    localparam logic [7:0]       CSUM_XOR = 8'hFF;

    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_B = 2'd1;

    typedef struct packed {
        logic [1:0]  slot;
        logic [63:0] scrambled_low;
        logic [31:0] scrambled_high;
        logic [63:0] seed;
    } t_req;

    typedef struct packed {
        logic        slot_out;
        logic [63:0] id_low;
        logic [31:0] id_high;
        logic [7:0]  id_checksum;
        logic        slot_error;
    } t_rsp;

    typedef struct packed {
        logic              en;
        logic [OPND_W-1:0] a;
    } t_mul_req;

endpackage

@@ hw/rtl/cdfi_mul.sv @@
// ----------------------------------------------------------------------------
// cdfi_mul
// Shared 32 x 31 multiplier by the generator constant, registered output.
// ----------------------------------------------------------------------------
module cdfi_mul (
    input  logic                       i_clk,
    input  cdfi_pkg::t_mul_req         i_req,
    output logic [cdfi_pkg::PROD_W-1:0] o_p
);

    logic [cdfi_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_p <= cdfi_pkg::PROD_W'(i_req.a) * cdfi_pkg::PROD_W'(cdfi_pkg::LCG_MUL);
        end
    end

    assign o_p = r_p;

endmodule

@@ hw/rtl/card_flash_id_descramble.sv @@
// ----------------------------------------------------------------------------
// card_flash_id_descramble
// Descrambles a twelve-byte card flash ID with an LCG keystream.
// 24 generator steps: low partial product, high partial product only when
// the state's upper word is nonzero, then sum. Words load in S_IDLE and the
// output register is written in S_DONE, which invalid slots reach directly.
// One word at a time; sync active-low reset clears sequencer and valid.
// ----------------------------------------------------------------------------
`include "card_flash_id_descramble_assert.svh"

module card_flash_id_descramble (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cdfi_pkg::t_req   i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cdfi_pkg::t_rsp   o_out
);

    typedef enum logic [2:0] {S_IDLE, S_LO, S_HI, S_SUM, S_DONE} t_state;

    t_state                        r_state, n_state;
    logic [cdfi_pkg::X_W-1:0]      r_x, n_x;
    logic [cdfi_pkg::ID_W-1:0]     r_data, n_data;
    logic [cdfi_pkg::ID_W-1:0]     r_id, n_id;
    logic [7:0]                    r_sum, n_sum;
    logic [cdfi_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_step2, n_step2;
    logic                          r_hi, n_hi;
    logic                          r_slot, n_slot;
    logic                          r_err, n_err;
    logic [cdfi_pkg::PROD_W-1:0]   r_plo, n_plo;
    logic                          r_out_valid, n_out_valid;
    cdfi_pkg::t_rsp                r_out, n_out;

    cdfi_pkg::t_mul_req            mul_req;
    logic [cdfi_pkg::PROD_W-1:0]   mul_p;
    logic [cdfi_pkg::PROD_W-1:0]   plo;
    logic [cdfi_pkg::OPND_W-1:0]   phi;
    logic [cdfi_pkg::X_W-1:0]      x_full;
    logic [cdfi_pkg::X_W-cdfi_pkg::SHIFT-1:0] x_new;
    logic [7:0]                    plain;
    logic                          last_step;
    logic                          err_rsp_zero;

    cdfi_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_p   (mul_p)
    );

    assign plo    = r_hi ? r_plo : mul_p;
    assign phi    = r_hi ? mul_p[cdfi_pkg::OPND_W-1:0] : '0;
    assign x_full = cdfi_pkg::X_W'(plo) + {phi, 32'b0} + cdfi_pkg::X_W'(cdfi_pkg::LCG_ADD);
    assign x_new  = x_full[cdfi_pkg::X_W-1:cdfi_pkg::SHIFT];
    assign plain  = r_data[7:0] - x_new[7:0];

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_data      = r_data;
        n_id        = r_id;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_step2     = r_step2;
        n_hi        = r_hi;
        n_slot      = r_slot;
        n_err       = r_err;
        n_plo       = r_plo;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mul_req.en  = 1'b0;
        mul_req.a   = r_x[cdfi_pkg::OPND_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_data  = {i_in.scrambled_high, i_in.scrambled_low};
                    n_x     = i_in.seed;
                    n_cnt   = '0;
                    n_step2 = 1'b0;
                    n_sum   = '0;
                    n_slot  = i_in.slot[0];
                    if (i_in.slot != cdfi_pkg::SLOT_A && i_in.slot != cdfi_pkg::SLOT_B) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_LO;
                    end
                end
            end
            S_LO: begin
                mul_req.en = 1'b1;
                n_hi       = (r_x[cdfi_pkg::X_W-1:cdfi_pkg::OPND_W] != '0);
                n_state    = n_hi ? S_HI : S_SUM;
            end
            S_HI: begin
                mul_req.en = 1'b1;
                mul_req.a  = r_x[cdfi_pkg::X_W-1:cdfi_pkg::OPND_W];
                n_plo      = mul_p;
                n_state    = S_SUM;
            end
            S_SUM: begin
                if (!r_step2) begin
                    n_id    = {plain, r_id[cdfi_pkg::ID_W-1:8]};
                    n_sum   = r_sum + plain;
                    n_data  = {8'b0, r_data[cdfi_pkg::ID_W-1:8]};
                    n_x     = cdfi_pkg::X_W'(x_new);
                    n_step2 = 1'b1;
                    n_state = S_LO;
                end else begin
                    n_x     = cdfi_pkg::X_W'(x_new[cdfi_pkg::MASK_W-1:0]);
                    n_step2 = 1'b0;
                    if (r_cnt == cdfi_pkg::CNT_W'(cdfi_pkg::ID_BYTES - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_LO;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (r_err) begin
                        n_out = '{slot_out: 1'b0, id_low: '0, id_high: '0,
                                  id_checksum: '0, slot_error: 1'b1};
                    end else begin
                        n_out = '{slot_out: r_slot, id_low: r_id[63:0],
                                  id_high: r_id[cdfi_pkg::ID_W-1:64],
                                  id_checksum: r_sum ^ cdfi_pkg::CSUM_XOR,
                                  slot_error: 1'b0};
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_x         <= n_x;
            r_data      <= n_data;
            r_id        <= n_id;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_step2     <= n_step2;
            r_hi        <= n_hi;
            r_slot      <= n_slot;
            r_err       <= n_err;
            r_plo       <= n_plo;
            r_out       <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign last_step    = (r_state == S_SUM) && r_step2 &&
                          (r_cnt == cdfi_pkg::CNT_W'(cdfi_pkg::ID_BYTES - 1));
    assign err_rsp_zero = (o_out.id_low == '0) && (o_out.id_high == '0) &&
                          (o_out.id_checksum == '0) && !o_out.slot_out;

    `CDFI_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `CDFI_ASSERT_IMPL(a_hi_follows_lo, r_state == S_HI, $past(r_state) == S_LO)
    `CDFI_ASSERT_NEXT(a_last_step_done, last_step, r_state == S_DONE)
    `CDFI_ASSERT_IMPL(a_error_zero, o_out_valid && o_out.slot_error, err_rsp_zero)

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for card_flash_id_descramble. Drives directed corner
// words and then random words under random idle and stall, predicts every ID
// word in a scoreboard and compares each output word field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          N_WORDS     = 1150;
    localparam int          CYCLE_LIMIT = 750000;
    localparam int          TAIL_CYCLES = 80;
    localparam int          HOLD_CYCLES = 400;
    localparam int          HOLD_AT     = 300;
    localparam int          DRAIN_AT    = 800;
    localparam int          CALM_FROM   = 450;
    localparam int          CALM_TO     = 700;
    localparam int          IDLE_PCT    = 17;
    localparam logic [1:0]  SLOT_BAD2   = 2'd2;
    localparam logic [1:0]  SLOT_BAD3   = 2'd3;
    localparam logic [63:0] ONES64      = '1;
    localparam logic [31:0] ONES32      = '1;

    class id_scoreboard;
        cdfi_pkg::t_rsp pending_ids[$];
        int unsigned    n_bad;
        int unsigned    n_seen;

        function new();
            n_bad  = 0;
            n_seen = 0;
        endfunction

        function logic [63:0] lcg_step(logic [63:0] x);
            logic [63:0] p;
            p = x * cdfi_pkg::LCG_MUL + cdfi_pkg::LCG_ADD;
            return p >> cdfi_pkg::SHIFT;
        endfunction

        function cdfi_pkg::t_rsp descramble(cdfi_pkg::t_req r);
            cdfi_pkg::t_rsp res;
            logic [63:0]    x;
            logic [95:0]    data;
            logic [95:0]    id;
            logic [7:0]     plain;
            logic [7:0]     sum;
            res = '0;
            if (r.slot != cdfi_pkg::SLOT_A && r.slot != cdfi_pkg::SLOT_B) begin
                res.slot_error = 1'b1;
                return res;
            end
            data = {r.scrambled_high, r.scrambled_low};
            id   = '0;
            sum  = '0;
            x    = r.seed;
            for (int k = 0; k < cdfi_pkg::ID_BYTES; k++) begin
                x = lcg_step(x);
                plain = data[8*k +: 8] - x[7:0];
                id[8*k +: 8] = plain;
                sum = sum + plain;
                x = lcg_step(x) & 64'h7fff;
            end
            res.slot_out    = r.slot[0];
            res.id_low      = id[63:0];
            res.id_high     = id[95:64];
            res.id_checksum = sum ^ cdfi_pkg::CSUM_XOR;
            return res;
        endfunction

        function void note_request(cdfi_pkg::t_req r);
            pending_ids.push_back(descramble(r));
        endfunction

        function void check_id(cdfi_pkg::t_rsp got);
            cdfi_pkg::t_rsp want;
            n_seen++;
            if (pending_ids.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: unexpected ID word %h", got);
                return;
            end
            want = pending_ids.pop_front();
            if (got.slot_out !== want.slot_out || got.id_low !== want.id_low ||
                got.id_high !== want.id_high || got.id_checksum !== want.id_checksum ||
                got.slot_error !== want.slot_error) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("ERROR: ID word %0d mismatch", n_seen);
                    $display("  exp slot=%0d lo=%h hi=%h csum=%h err=%0d", want.slot_out,
                             want.id_low, want.id_high, want.id_checksum, want.slot_error);
                    $display("  got slot=%0d lo=%h hi=%h csum=%h err=%0d", got.slot_out,
                             got.id_low, got.id_high, got.id_checksum, got.slot_error);
                end
            end
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           i_out_stall = 1'b0;
    cdfi_pkg::t_req i_in        = '0;
    logic           o_in_stall;
    logic           o_out_valid;
    cdfi_pkg::t_rsp o_out;

    bit           calm;
    bit           hold_done;
    int           cycle_count;
    id_scoreboard sb = new();

    card_flash_id_descramble dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic cdfi_pkg::t_req req_of(logic [1:0] slot, logic [31:0] hi,
                                              logic [63:0] lo, logic [63:0] seed);
        cdfi_pkg::t_req r;
        r.slot           = slot;
        r.scrambled_high = hi;
        r.scrambled_low  = lo;
        r.seed           = seed;
        return r;
    endfunction

    function automatic cdfi_pkg::t_req rand_request();
        cdfi_pkg::t_req r;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 44)
            r.slot = cdfi_pkg::SLOT_A;
        else if (pick < 88)
            r.slot = cdfi_pkg::SLOT_B;
        else
            r.slot = pick[0] ? SLOT_BAD3 : SLOT_BAD2;
        r.scrambled_low  = rnd64();
        r.scrambled_high = $urandom;
        pick = $urandom_range(9);
        if (pick < 5)
            r.seed = rnd64();
        else if (pick < 7)
            r.seed = {32'd0, $urandom};
        else if (pick < 8)
            r.seed = 64'($urandom_range(16'hffff));
        else if (pick < 9)
            r.seed = {32'hffff_ffff, $urandom};
        else
            r.seed = {$urandom, 32'd0};
        return r;
    endfunction

    task automatic send_word(input cdfi_pkg::t_req w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            i_in       <= rand_request();
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_request(w);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_ids.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall, one long hold-off, calm window
    initial begin
        forever begin
            @(posedge i_clk);
            if (!hold_done && sb.n_seen >= HOLD_AT) begin
                i_out_stall <= 1'b1;
                for (int h = 0; h < HOLD_CYCLES; h++) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            sb.check_id(o_out);
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("TIMEOUT after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int n_dir;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(req_of(cdfi_pkg::SLOT_A, 32'd0, 64'd0, 64'd0));
        send_word(req_of(cdfi_pkg::SLOT_B, ONES32, ONES64, ONES64));
        send_word(req_of(cdfi_pkg::SLOT_A, ONES32, ONES64, 64'd0));
        send_word(req_of(cdfi_pkg::SLOT_B, 32'd0, 64'd0, ONES64));
        send_word(req_of(cdfi_pkg::SLOT_A, 32'ha5a5_a5a5, 64'ha5a5_a5a5_a5a5_a5a5, 64'd1));
        send_word(req_of(cdfi_pkg::SLOT_B, 32'h5a5a_5a5a, 64'h5a5a_5a5a_5a5a_5a5a,
                         64'h8000_0000_0000_0000));
        send_word(req_of(cdfi_pkg::SLOT_A, $urandom, rnd64(), 64'h0000_0000_ffff_ffff));
        send_word(req_of(cdfi_pkg::SLOT_B, $urandom, rnd64(), 64'h0000_0001_0000_0000));
        send_word(req_of(cdfi_pkg::SLOT_A, $urandom, rnd64(), 64'h7fff));
        send_word(req_of(cdfi_pkg::SLOT_B, $urandom, rnd64(), 64'h7fff_ffff_ffff_ffff));
        send_word(req_of(SLOT_BAD2, $urandom, rnd64(), rnd64()));
        send_word(req_of(SLOT_BAD3, 32'd0, 64'd0, 64'd0));
        send_word(req_of(SLOT_BAD3, ONES32, ONES64, ONES64));
        send_word(req_of(SLOT_BAD2, ONES32, ONES64, 64'd0));
        send_word(req_of(cdfi_pkg::SLOT_A, $urandom, rnd64(), rnd64()));
        send_word(req_of(cdfi_pkg::SLOT_B, $urandom, rnd64(), rnd64()));
        n_dir = 16;

        for (int n = n_dir; n < N_WORDS; n++) begin
            if (n == DRAIN_AT)
                wait_drained();
            calm = (n >= CALM_FROM && n < CALM_TO);
            send_word(rand_request());
        end
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.pending_ids.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cdfi_pkg.sv
hw/rtl/cdfi_mul.sv
hw/rtl/card_flash_id_descramble.sv
tb/sv/tb_top.sv
